@@ hdl/mecu_pkg.sv @@
// Shared types, constants and helpers for the mecanum body-velocity unit.
// No dependencies; used by the lane, merge and top-level modules.
`default_nettype none
package mecu_pkg;

  localparam logic [29:0] NS_PER_S = 30'd1000000000;

  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_RPM      = 3'd1;
  localparam logic [2:0] CFG_TICK     = 3'd2;
  localparam logic [2:0] CFG_LINEAR   = 3'd3;
  localparam logic [2:0] CFG_ROTATION = 3'd4;

  localparam int unsigned NUM_WHEELS = 4;

  typedef enum logic [6:0] {
    LN_IDLE  = 7'b0000001,
    LN_NUM   = 7'b0000010,
    LN_CHK   = 7'b0000100,
    LN_DIV   = 7'b0001000,
    LN_SCALE = 7'b0010000,
    LN_RND   = 7'b0100000,
    LN_DONE  = 7'b1000000
  } lane_state_e;

  typedef enum logic [6:0] {
    TOP_IDLE   = 7'b0000001,
    TOP_GAP1   = 7'b0000010,
    TOP_GAP2   = 7'b0000100,
    TOP_LANES  = 7'b0001000,
    TOP_MSTART = 7'b0010000,
    TOP_MERGE  = 7'b0100000,
    TOP_PUSH   = 7'b1000000
  } top_state_e;

  typedef struct packed {
    logic start;
    logic mode;
    logic hold;
  } lane_cmd_t;

  // Reapply sign and saturate a magnitude to signed 32 bits.
  function automatic logic signed [31:0] sat_sign(input logic neg, input logic [63:0] mag);
    logic signed [31:0] res;
    if (neg) begin
      if (mag >= 64'h8000_0000) res = 32'sh8000_0000;
      else res = -$signed(mag[31:0]);
    end else begin
      if (mag > 64'h7FFF_FFFF) res = 32'sh7FFF_FFFF;
      else res = $signed(mag[31:0]);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ hdl/mecu_lane.sv @@
// One wheel lane: RPM scaling or tick difference, bit-serial rate divide, scaling.
// Depends on mecu_pkg.
`default_nettype none
module mecu_lane #(
  parameter int unsigned SCALE_FRAC_BITS = 24
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  mecu_pkg::lane_cmd_t cmd_i,
  input  wire        [63:0] gap_i,
  input  wire signed [31:0] rpm_i,
  input  wire signed [31:0] ticks_i,
  input  wire        [31:0] rpm_scale_i,
  input  wire        [31:0] tick_scale_i,
  output logic              done_o,
  output logic signed [31:0] speed_o
);
  localparam int unsigned SHR = 31 - SCALE_FRAC_BITS;
  localparam int unsigned NW  = 63 + SCALE_FRAC_BITS;
  localparam logic [29:0] NS_PER_WIDE = mecu_pkg::NS_PER_S;

  mecu_pkg::lane_state_e state_q, state_d;
  logic signed [31:0] last_ticks_q;
  logic signed [31:0] speed_q;
  logic        [32:0] dmag_q;
  logic        [62:0] num_q;
  logic        [63:0] rem_q;
  logic        [30:0] low_q;
  logic        [30:0] quo_q;
  logic        [4:0]  cnt_q;
  logic               neg_q;
  logic               vel_q;
  logic               sat_q;
  logic        [31:0] mag_q;
  logic        [63:0] prod_q;

  logic signed [32:0] dt;
  logic        [NW-1:0] nsh;
  logic        [63:0] top;
  logic        [63:0] rem2;
  logic        [63:0] rnd16;
  logic        [63:0] rndf;

  assign dt   = {ticks_i[31], ticks_i} - {last_ticks_q[31], last_ticks_q};
  assign nsh  = {num_q, {SCALE_FRAC_BITS{1'b0}}};
  assign top  = 64'(num_q >> SHR);
  assign rem2 = {rem_q[62:0], low_q[30]};
  assign rnd16 = (prod_q + 64'h8000) >> 16;
  assign rndf  = (prod_q + (64'd1 << (SCALE_FRAC_BITS - 1))) >> SCALE_FRAC_BITS;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mecu_pkg::LN_IDLE: begin
        if (cmd_i.start) begin
          if (!cmd_i.mode) state_d = mecu_pkg::LN_SCALE;
          else if (cmd_i.hold) state_d = mecu_pkg::LN_DONE;
          else state_d = mecu_pkg::LN_NUM;
        end
      end
      mecu_pkg::LN_NUM:   state_d = mecu_pkg::LN_CHK;
      // run the full divide even when saturated so all lanes stay in step
      mecu_pkg::LN_CHK:   state_d = mecu_pkg::LN_DIV;
      mecu_pkg::LN_DIV:   state_d = (cnt_q == 5'd1) ? mecu_pkg::LN_SCALE : mecu_pkg::LN_DIV;
      mecu_pkg::LN_SCALE: state_d = mecu_pkg::LN_RND;
      mecu_pkg::LN_RND:   state_d = mecu_pkg::LN_DONE;
      mecu_pkg::LN_DONE:  state_d = mecu_pkg::LN_IDLE;
      default:            state_d = mecu_pkg::LN_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mecu_pkg::LN_IDLE;
      speed_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == mecu_pkg::LN_RND) begin
        speed_q <= mecu_pkg::sat_sign(neg_q, vel_q ? rnd16 : rndf);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mecu_pkg::LN_IDLE: begin
        if (cmd_i.start) begin
          vel_q <= !cmd_i.mode;
          if (!cmd_i.mode) begin
            neg_q <= rpm_i[31];
            mag_q <= rpm_i[31] ? 32'(-{rpm_i[31], rpm_i}) : rpm_i;
          end else begin
            neg_q  <= dt[32];
            dmag_q <= dt[32] ? 33'(-dt) : dt;
            last_ticks_q <= ticks_i;
          end
        end
      end
      mecu_pkg::LN_NUM: num_q <= 63'(dmag_q * NS_PER_WIDE);
      mecu_pkg::LN_CHK: begin
        rem_q <= top;
        low_q <= nsh[30:0];
        quo_q <= '0;
        cnt_q <= 5'd31;
        sat_q <= (top >= gap_i);
        // saturated rate: sign picks the extreme
        mag_q <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      mecu_pkg::LN_DIV: begin
        if (rem2 >= gap_i) begin
          rem_q <= rem2 - gap_i;
          quo_q <= {quo_q[29:0], 1'b1};
        end else begin
          rem_q <= rem2;
          quo_q <= {quo_q[29:0], 1'b0};
        end
        low_q <= {low_q[29:0], 1'b0};
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1 && !sat_q) mag_q <= {quo_q, (rem2 >= gap_i)};
      end
      mecu_pkg::LN_SCALE: prod_q <= mag_q * (vel_q ? rpm_scale_i : tick_scale_i);
      default: ;
    endcase
  end

  assign done_o  = (state_q == mecu_pkg::LN_DONE);
  assign speed_o = speed_q;

endmodule
`default_nettype wire

@@ hdl/mecu_merge.sv @@
// Merge stage: combines four wheel speeds into body vx, vy and yaw rate.
// Depends on mecu_pkg.
`default_nettype none
module mecu_merge #(
  parameter int unsigned SCALE_FRAC_BITS = 24
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire signed [31:0] speed_i [mecu_pkg::NUM_WHEELS],
  input  wire        [31:0] linear_scale_i,
  input  wire        [31:0] rotation_scale_i,
  output logic              done_o,
  output logic signed [31:0] body_o [3]
);
  logic [2:0] stg_q;
  logic [2:0] neg_q;
  logic [33:0] mag_q [3];
  logic [65:0] prod_q [3];
  logic signed [31:0] body_q [3];

  logic signed [34:0] fl, fr, rl, rr;
  logic signed [34:0] sum [3];
  logic [31:0] scl [3];

  assign fl = 35'(speed_i[0]);
  assign fr = 35'(speed_i[1]);
  assign rl = 35'(speed_i[2]);
  assign rr = 35'(speed_i[3]);
  assign sum[0] =  fl + fr + rl + rr;
  assign sum[1] = -fl + fr + rl - rr;
  assign sum[2] = -fl + fr - rl + rr;
  assign scl[0] = linear_scale_i;
  assign scl[1] = linear_scale_i;
  assign scl[2] = rotation_scale_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) stg_q <= '0;
    else stg_q <= {stg_q[1:0], start_i};
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (start_i) begin
        neg_q[k] <= sum[k][34];
        mag_q[k] <= sum[k][34] ? 34'(-sum[k]) : 34'(sum[k]);
      end
      if (stg_q[0]) begin
        prod_q[k] <= 66'(mag_q[k][31:0] * scl[k])
                   + ({34'(mag_q[k][33:32] * scl[k]), 32'd0});
      end
      if (stg_q[1]) begin
        body_q[k] <= mecu_pkg::sat_sign(neg_q[k],
          64'((prod_q[k] + (66'd1 << (SCALE_FRAC_BITS - 1))) >> SCALE_FRAC_BITS));
      end
    end
  end

  assign done_o = stg_q[2];
  assign body_o = body_q;

endmodule
`default_nettype wire

@@ hdl/mecanum_encoder_to_body_velocity_unit.sv @@
// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | timestamp, four RPM readings, four tick counts
// m_axis   | out | m_axis_tvalid/m_axis_tready  | vx, vy, yaw rate, timestamp; tuser = mode
// cfg      | in  | cfg_valid_i/cfg_ready_o      | register index, 32-bit value
// Position mode first forms the time gap (GAP1, GAP2); then each lane's one-bit-per-cycle
// restoring divider (31 steps) dominates; velocity mode skips the gap and the divide,
// and held position samples skip the divide.
// One item is in flight at a time; the result waits in the output register and
// the next item is taken once it is free. Reset is asynchronous, active low.
// Top level; depends on mecu_pkg, mecu_lane and mecu_merge.
`default_nettype none
module mecanum_encoder_to_body_velocity_unit #(
  parameter int unsigned SCALE_FRAC_BITS = 24
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // sec[31:0] nanos[61:32] rpm fl,fr,rl,rr [189:62] ticks fl,fr,rl,rr [317:190]
  input  wire  [319:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // vx[31:0] vy[63:32] yaw[95:64] sec[127:96] nanos[157:128]
  output logic [159:0] m_axis_tdata,
  // mode_echo[0]
  output logic [0:0]   m_axis_tuser,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [2:0]   cfg_index_i,
  input  wire  [31:0]  cfg_data_i
);
  localparam int unsigned NW = mecu_pkg::NUM_WHEELS;

  mecu_pkg::top_state_e state_q, state_d;
  logic        mode_q, rpm_dummy;
  logic [31:0] rpm_scale_q, tick_scale_q, linear_scale_q, rotation_scale_q;
  logic        first_q;
  logic [31:0] last_sec_q;
  logic [29:0] last_ns_q;
  logic [31:0] sec_q;
  logic [29:0] ns_q;
  logic        imode_q;
  logic signed [31:0] rpm_q [NW];
  logic signed [31:0] tick_q [NW];
  logic signed [63:0] gmul_q;
  logic [63:0] gap_q;
  logic        hold_q;
  logic        out_valid_q;
  logic [159:0] out_data_q;
  logic         out_mode_q;

  logic signed [32:0] sdiff;
  logic signed [30:0] nsdiff;
  logic signed [63:0] gap;
  logic               accept;
  logic [NW-1:0]      lane_done;
  logic signed [31:0] speed [NW];
  logic signed [31:0] body [3];
  logic               merge_done;
  mecu_pkg::lane_cmd_t lane_cmd;

  assign rpm_dummy = 1'b0;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == mecu_pkg::TOP_IDLE);
  assign cfg_ready_o = 1'b1;

  assign sdiff  = {1'b0, sec_q} - {1'b0, last_sec_q};
  assign nsdiff = {1'b0, ns_q} - {1'b0, last_ns_q};
  assign gap    = gmul_q + 64'(nsdiff);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mecu_pkg::TOP_IDLE:
        if (accept) state_d = mode_q ? mecu_pkg::TOP_GAP1 : mecu_pkg::TOP_LANES;
      mecu_pkg::TOP_GAP1:   state_d = mecu_pkg::TOP_GAP2;
      mecu_pkg::TOP_GAP2:   state_d = mecu_pkg::TOP_LANES;
      mecu_pkg::TOP_LANES:  if (lane_done[0]) state_d = mecu_pkg::TOP_MSTART;
      mecu_pkg::TOP_MSTART: state_d = mecu_pkg::TOP_MERGE;
      mecu_pkg::TOP_MERGE:  if (merge_done) state_d = mecu_pkg::TOP_PUSH;
      mecu_pkg::TOP_PUSH:
        if (!out_valid_q || m_axis_tready) state_d = mecu_pkg::TOP_IDLE;
      default: state_d = mecu_pkg::TOP_IDLE;
    endcase
  end

  // Start the lanes in the first cycle of the lane state.
  logic lane_go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= mecu_pkg::TOP_IDLE;
      mode_q           <= 1'b1;
      rpm_scale_q      <= '0;
      tick_scale_q     <= '0;
      linear_scale_q   <= '0;
      rotation_scale_q <= '0;
      first_q          <= 1'b1;
      out_valid_q      <= 1'b0;
      lane_go_q        <= 1'b0;
    end else begin
      state_q   <= state_d;
      lane_go_q <= (state_q != mecu_pkg::TOP_LANES) && (state_d == mecu_pkg::TOP_LANES);
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          mecu_pkg::CFG_MODE:     mode_q           <= cfg_data_i[0];
          mecu_pkg::CFG_RPM:      rpm_scale_q      <= cfg_data_i;
          mecu_pkg::CFG_TICK:     tick_scale_q     <= cfg_data_i;
          mecu_pkg::CFG_LINEAR:   linear_scale_q   <= cfg_data_i;
          mecu_pkg::CFG_ROTATION: rotation_scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == mecu_pkg::TOP_GAP2) first_q <= 1'b0;
      if (state_q == mecu_pkg::TOP_PUSH && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sec_q   <= s_axis_tdata[31:0];
      ns_q    <= s_axis_tdata[61:32];
      imode_q <= mode_q;
      for (int k = 0; k < NW; k++) begin
        rpm_q[k]  <= s_axis_tdata[62 + 32*k +: 32];
        tick_q[k] <= s_axis_tdata[190 + 32*k +: 32];
      end
    end
    if (state_q == mecu_pkg::TOP_GAP1) begin
      gmul_q <= 64'(sdiff * $signed({1'b0, mecu_pkg::NS_PER_S}));
    end
    if (state_q == mecu_pkg::TOP_GAP2) begin
      gap_q      <= gap;
      hold_q     <= first_q || (gap <= 64'sd0);
      last_sec_q <= sec_q;
      last_ns_q  <= ns_q;
    end
    if (state_q == mecu_pkg::TOP_PUSH && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {2'b00, ns_q, sec_q, body[2], body[1], body[0]};
      out_mode_q <= imode_q | rpm_dummy;
    end
  end

  assign lane_cmd = '{start: lane_go_q, mode: imode_q, hold: hold_q};

  for (genvar g = 0; g < NW; g++) begin : g_lane
    mecu_lane #(.SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (lane_cmd),
      .gap_i        (gap_q),
      .rpm_i        (rpm_q[g]),
      .ticks_i      (tick_q[g]),
      .rpm_scale_i  (rpm_scale_q),
      .tick_scale_i (tick_scale_q),
      .done_o       (lane_done[g]),
      .speed_o      (speed[g])
    );
  end

  mecu_merge #(.SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (state_q == mecu_pkg::TOP_MSTART),
    .speed_i          (speed),
    .linear_scale_i   (linear_scale_q),
    .rotation_scale_i (rotation_scale_q),
    .done_o           (merge_done),
    .body_o           (body)
  );

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_mode_q;

`ifndef NO_ASSERTIONS
  a_lanes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|lane_done) |-> (&lane_done)) else $error("lanes finished out of step");
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready) else $error("second item taken while busy");
  a_first_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mecu_pkg::TOP_PUSH && imode_q) |-> !first_q)
    else $error("position item finished with first-sample flag still set");
  a_merge_after_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_done |-> (state_q == mecu_pkg::TOP_MERGE)) else $error("stray merge result");
`endif

endmodule
`default_nettype wire

@@ test/tb_mecanum_encoder_to_body_velocity_unit.sv @@
// Testbench for mecanum_encoder_to_body_velocity_unit: drives encoder samples and
// register writes, predicts every body velocity result and checks it field by field.
// Depends on mecu_pkg and the unit's RTL only.
`default_nettype none
module tb_mecanum_encoder_to_body_velocity_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 24;
  localparam longint NS_SCALE = 64'd1000000000;

  typedef struct packed {
    logic [31:0]      sec;
    logic [29:0]      ns;
    logic [3:0][31:0] rpm;
    logic [3:0][31:0] ticks;
  } sample_t;

  typedef struct packed {
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] yaw;
    logic [31:0] sec;
    logic [29:0] ns;
    logic        mode;
  } body_vel_t;

  logic         clk;
  logic         rst_n;
  logic         s_tvalid;
  logic         s_tready;
  logic [319:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [159:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  mecanum_encoder_to_body_velocity_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .m_axis_tuser(m_tuser),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Shadow of the unit's registers and state
  logic                    sh_mode;
  logic [31:0]             sh_rpm_scale, sh_tick_scale, sh_lin_scale, sh_rot_scale;
  logic                    sh_first;
  logic [31:0]             sh_last_sec;
  logic [29:0]             sh_last_ns;
  logic signed [3:0][31:0] sh_last_ticks;
  logic signed [3:0][31:0] sh_wheel;

  body_vel_t expected_vel[$];
  int        fail_count;
  bit        calm;

  // Stimulus-side running position for well-formed sequences
  logic [31:0] cur_sec;
  logic [29:0] cur_ns;
  logic [3:0][31:0] cur_ticks;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [31:0] saturate_signed(bit neg, logic [63:0] mag);
    if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // round(a * s / 2^sh), half away from zero, saturated
  function automatic logic [31:0] scale_product(longint a, logic [31:0] s, int sh);
    bit          neg;
    logic [63:0] m, hi, lo, half, r;
    neg  = a < 0;
    m    = neg ? 64'(-a) : 64'(a);
    hi   = m >> 32;
    lo   = m & 64'hFFFF_FFFF;
    half = 64'd1 << (sh - 1);
    r    = ((hi * {32'd0, s}) << (32 - sh)) + ((lo * {32'd0, s} + half) >> sh);
    return saturate_signed(neg, r);
  endfunction

  // ticks per second with FRAC fraction bits, magnitude truncated
  function automatic logic [31:0] tick_rate_of(longint dt, longint gap);
    bit          neg;
    logic [63:0] m, g, num, ip, rem, q;
    neg = dt < 0;
    m   = neg ? 64'(-dt) : 64'(dt);
    g   = 64'(gap);
    num = m * 64'd1000000000;
    ip  = num / g;
    rem = num % g;
    if (ip >= (64'd1 << (31 - FRAC))) begin
      q = 64'h8000_0000;
    end else begin
      q = ip;
      for (int i = 0; i < FRAC; i++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= g) begin
          rem = rem - g;
          q   = q | 64'd1;
        end
      end
    end
    return saturate_signed(neg, q);
  endfunction

  function automatic body_vel_t predict_body_velocity(sample_t smp);
    body_vel_t r;
    bit        hold;
    longint    gap, dt, fl, fr, rl, rr;
    gap = 0;
    if (sh_mode == 1'b0) begin
      for (int i = 0; i < 4; i++)
        sh_wheel[i] = scale_product(longint'($signed(smp.rpm[i])), sh_rpm_scale, 16);
    end else begin
      hold = sh_first;
      if (!hold) begin
        gap = (longint'(smp.sec) - longint'(sh_last_sec)) * NS_SCALE
            + (longint'(smp.ns) - longint'(sh_last_ns));
        if (gap <= 0) hold = 1'b1;
      end
      sh_last_sec = smp.sec;
      sh_last_ns  = smp.ns;
      sh_first    = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (!hold) begin
          dt = longint'($signed(smp.ticks[i])) - longint'($signed(sh_last_ticks[i]));
          sh_wheel[i] = scale_product(longint'($signed(tick_rate_of(dt, gap))),
                                      sh_tick_scale, FRAC);
        end
        sh_last_ticks[i] = smp.ticks[i];
      end
    end
    fl = longint'($signed(sh_wheel[0]));
    fr = longint'($signed(sh_wheel[1]));
    rl = longint'($signed(sh_wheel[2]));
    rr = longint'($signed(sh_wheel[3]));
    r.vx   = scale_product(fl + fr + rl + rr, sh_lin_scale, FRAC);
    r.vy   = scale_product(-fl + fr + rl - rr, sh_lin_scale, FRAC);
    r.yaw  = scale_product(-fl + fr - rl + rr, sh_rot_scale, FRAC);
    r.sec  = smp.sec;
    r.ns   = smp.ns;
    r.mode = sh_mode;
    return r;
  endfunction

  // Receiver: stall at random unless in a calm stretch
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
    end
  end

  task automatic report(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    body_vel_t e;
    if (rst_n && m_tvalid && m_tready) begin
      if (expected_vel.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
      end else begin
        e = expected_vel.pop_front();
        report("vx", e.vx, m_tdata[31:0]);
        report("vy", e.vy, m_tdata[63:32]);
        report("yaw", e.yaw, m_tdata[95:64]);
        report("seconds", e.sec, m_tdata[127:96]);
        report("nanos", {2'b0, e.ns}, {2'b0, m_tdata[157:128]});
        report("mode", {31'd0, e.mode}, {31'd0, m_tuser[0]});
      end
    end
  end

  task automatic send_sample(sample_t smp);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b0, smp.ticks[3], smp.ticks[2], smp.ticks[1], smp.ticks[0],
                 smp.rpm[3], smp.rpm[2], smp.rpm[1], smp.rpm[0], smp.ns, smp.sec};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_vel.push_back(predict_body_velocity(smp));
    if (!calm && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_register(logic [2:0] idx, logic [31:0] val, bit last_one);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mecu_pkg::CFG_MODE:     sh_mode       = val[0];
      mecu_pkg::CFG_RPM:      sh_rpm_scale  = val;
      mecu_pkg::CFG_TICK:     sh_tick_scale = val;
      mecu_pkg::CFG_LINEAR:   sh_lin_scale  = val;
      mecu_pkg::CFG_ROTATION: sh_rot_scale  = val;
      default: ;
    endcase
    if (last_one) cfg_valid <= 1'b0;
  endtask

  task automatic load_config(logic [31:0] mode_word, logic [31:0] rpm_s, logic [31:0] tick_s,
                             logic [31:0] lin_s, logic [31:0] rot_s);
    write_register(mecu_pkg::CFG_MODE, mode_word, 1'b0);
    write_register(mecu_pkg::CFG_RPM, rpm_s, 1'b0);
    write_register(mecu_pkg::CFG_TICK, tick_s, 1'b0);
    write_register(mecu_pkg::CFG_LINEAR, lin_s, 1'b0);
    write_register(mecu_pkg::CFG_ROTATION, rot_s, 1'b1);
  endtask

  // Drain all results and let the unit settle before touching registers
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_vel.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(32'h0400_0000);
      3: return $urandom_range(32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.sec = $urandom;
    s.ns  = $urandom;
    for (int i = 0; i < 4; i++) begin
      s.rpm[i]   = $urandom;
      s.ticks[i] = $urandom;
    end
    return s;
  endfunction

  // Next sample of a plausible trajectory: usually ~20 ms later, mostly modest tick deltas
  function automatic sample_t next_sample();
    sample_t     s;
    logic [31:0] step;
    step = ($urandom_range(9) == 0) ? $urandom_range(1, 1000) :
                                      $urandom_range(15_000_000, 25_000_000);
    if (longint'(cur_ns) + step >= NS_SCALE) begin
      cur_ns  = 30'(longint'(cur_ns) + step - NS_SCALE);
      cur_sec = cur_sec + 1;
    end else begin
      cur_ns = cur_ns + step[29:0];
    end
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(49) == 0) cur_ticks[i] = $urandom;
      else cur_ticks[i] = cur_ticks[i] + 32'($urandom_range(8000)) - 32'd4000;
      s.rpm[i]   = $urandom;
      s.ticks[i] = cur_ticks[i];
    end
    s.sec = cur_sec;
    s.ns  = cur_ns;
    return s;
  endfunction

  task automatic test_reset_state();
    sample_t s;
    // Reset registers: position mode, all scales zero
    for (int i = 0; i < 3; i++) begin
      s = random_sample();
      s.ns = $urandom_range(999_999_999);
      send_sample(s);
    end
    wait_idle();
    // Indexes past the register list are ignored
    write_register(3'd5, 32'hFFFF_FFFF, 1'b0);
    write_register(3'd6, 32'h1234_5678, 1'b0);
    write_register(3'd7, 32'hFFFF_FFFF, 1'b1);
    send_sample(random_sample());
    wait_idle();
  endtask

  task automatic test_velocity_extremes();
    sample_t s;
    logic [31:0] edge_vals [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1};
    load_config(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int k = 0; k < 5; k++) begin
      s = random_sample();
      for (int i = 0; i < 4; i++) s.rpm[i] = edge_vals[(k + i) % 5];
      send_sample(s);
    end
    s = random_sample();
    s.rpm = {4{32'h8000_0000}};
    send_sample(s);
    wait_idle();
    load_config(32'd0, 32'h0004_4444, 32'd0, 32'h0066_6666, 32'h0040_0000);
    s = random_sample();
    s.rpm = {32'hFFF0_0000, 32'h0010_0000, 32'h0000_8000, 32'hFFFF_8000};
    send_sample(s);
    wait_idle();
  endtask

  task automatic test_position_cases();
    sample_t s;
    load_config(32'd1, 32'd0, 32'h0000_0290, 32'h0066_6666, 32'h0040_0000);
    cur_sec = 32'd100;
    cur_ns = 30'd0;
    cur_ticks = '0;
    s = next_sample();
    send_sample(s);                       // gap measured against the sample stored by the earlier test
    s = next_sample();
    send_sample(s);
    send_sample(s);                       // zero gap: reload, hold speeds
    s.sec = s.sec - 1;
    send_sample(s);                       // negative gap
    s.sec = s.sec + 1;
    s.ns  = s.ns + 1;
    s.ticks[0] = s.ticks[0] + 32'h7FFF_FFFF;
    s.ticks[1] = s.ticks[1] - 32'h7FFF_FFFF;
    send_sample(s);                       // one second and a nanosecond, huge deltas: saturate
    s.ns  = 30'h3FFF_FFFF;                // nanos out of range, used as given
    s.ticks = {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_sample(s);
    s.sec = 32'hFFFF_FFFF;
    s.ticks = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    send_sample(s);
    s.sec = 32'd0;                        // wrap back: negative gap
    send_sample(s);
    wait_idle();
    load_config(32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    cur_sec = 32'd0;
    cur_ns = 30'd0;
    s = next_sample();
    s.ticks = {32'h0000_0100, 32'hFFFF_FF00, 32'd5, 32'hFFFF_FFFB};
    send_sample(s);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    sample_t s;
    int      n;
    for (int ph = 0; ph < 8; ph++) begin
      load_config(ph[0] ? 32'($urandom) | 32'd1 : 32'($urandom) & ~32'd1,
                  pick_scale(), pick_scale(), pick_scale(), pick_scale());
      calm = (ph == 3);
      cur_sec = $urandom;
      cur_ns  = $urandom_range(999_999_999);
      for (int i = 0; i < 4; i++) cur_ticks[i] = $urandom;
      n = 250;
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(9))
          0: s = random_sample();
          1: begin
            s = next_sample();
            s.sec = s.sec - 32'($urandom_range(2));
          end
          default: s = next_sample();
        endcase
        send_sample(s);
      end
      wait_idle();
      calm = 1'b0;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    fail_count = 0;
    sh_mode = 1'b1;
    sh_rpm_scale = '0;
    sh_tick_scale = '0;
    sh_lin_scale = '0;
    sh_rot_scale = '0;
    sh_first = 1'b1;
    sh_last_sec = '0;
    sh_last_ns = '0;
    sh_last_ticks = '0;
    sh_wheel = '0;
    cur_sec = '0;
    cur_ns = '0;
    cur_ticks = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_velocity_extremes();
    test_position_cases();
    test_random_traffic();

    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ mecanum_encoder_to_body_velocity_unit.f @@
hdl/mecu_pkg.sv
hdl/mecu_lane.sv
hdl/mecu_merge.sv
hdl/mecanum_encoder_to_body_velocity_unit.sv
test/tb_mecanum_encoder_to_body_velocity_unit.sv
